@@ sv/complex_fixed_point_alu_unit_defines.svh @@
// Assertion macros for the complex fixed-point ALU.
`ifndef COMPLEX_FIXED_POINT_ALU_UNIT_DEFINES_SVH
`define COMPLEX_FIXED_POINT_ALU_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CFPA_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CFPA_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ sv/cfpa_pkg.sv @@
// Package: widths, operation and status codes, saturation helpers.
`default_nettype none
package cfpa_pkg;

    localparam int DATA_W  = 16;
    localparam int FRAC_W  = 8;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;
    localparam int PROD_W  = 2 * DATA_W;          // product / sum-of-squares width
    localparam int Q_W     = DATA_W + 1;          // quotient bits kept
    localparam int NUM_W   = PROD_W + FRAC_W;     // scaled dividend
    localparam int REM_W   = PROD_W + Q_W;        // divider partial remainder
    localparam int ROOT_W  = DATA_W;
    localparam int SREM_W  = PROD_W + 1;
    localparam int DIV_STG = Q_W;                 // one quotient bit per stage
    localparam int MAG_W   = PROD_W + 1;

    // Operation codes
    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MOD  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CONJ = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_SAT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_DIV0 = 2'd2;

    localparam logic [MAG_W-1:0] POS_MAX = MAG_W'((64'd1 << (DATA_W - 1)) - 64'd1);
    localparam logic [MAG_W-1:0] NEG_MAG = MAG_W'(64'd1 << (DATA_W - 1));

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     clip;
    } t_sat;

    // Clamp a sign-magnitude value to the signed data range.
    function automatic t_sat sat_sm(input logic neg, input logic [MAG_W-1:0] mag);
        t_sat r;
        if (neg) begin
            if (mag > NEG_MAG) begin
                r.val  = {1'b1, {(DATA_W-1){1'b0}}};
                r.clip = 1'b1;
            end else begin
                r.val  = -$signed(mag[DATA_W-1:0]);
                r.clip = 1'b0;
            end
        end else begin
            if (mag > POS_MAX) begin
                r.val  = {1'b0, {(DATA_W-1){1'b1}}};
                r.clip = 1'b1;
            end else begin
                r.val  = $signed(mag[DATA_W-1:0]);
                r.clip = 1'b0;
            end
        end
        return r;
    endfunction

    // Clamp a two's complement value two bits wider than the data.
    function automatic t_sat sat_s(input logic signed [DATA_W+1:0] x);
        logic [MAG_W-1:0] mag;
        mag = x[DATA_W+1] ? MAG_W'(-x) : MAG_W'(x);
        return sat_sm(x[DATA_W+1], mag);
    endfunction

endpackage
`default_nettype wire

@@ sv/cfpa_if.sv @@
// Request and response channel interfaces.
`default_nettype none
interface cfpa_in_if import cfpa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] a_re;
    logic signed [DATA_W-1:0] a_im;
    logic signed [DATA_W-1:0] b_re;
    logic signed [DATA_W-1:0] b_im;

    modport source (output valid, cmd, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, cmd, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cfpa_out_if import cfpa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] res_re;
    logic signed [DATA_W-1:0] res_im;
    logic [STAT_W-1:0]        status;

    modport source (output valid, res_re, res_im, status, input ready);
    modport sink   (input valid, res_re, res_im, status, output ready);
endinterface
`default_nettype wire

@@ sv/complex_fixed_point_alu_unit.sv @@
// Complex fixed-point ALU: add, subtract, multiply, divide, modulus, conjugate.
// Pipelined complex Q8.8 ALU. A request is taken every cycle the pipeline is
// not stalled; each request yields one response after passing through the
// stages in order (operand products, sums, divider set-up, 17 restoring-divider
// stages, output register). The latency is set by the bit-per-stage divider;
// the square root runs alongside it in 16 of those stages. A stall on the
// response side freezes the whole pipeline and holds the request side not ready.
`default_nettype none
`include "complex_fixed_point_alu_unit_defines.svh"
module complex_fixed_point_alu_unit import cfpa_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    cfpa_in_if.sink    i_req,
    cfpa_out_if.source o_rsp
);

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic                     clip;
        logic                     dz;
        logic                     neg_r;
        logic                     neg_i;
        logic                     ovf_r;
        logic                     ovf_i;
    } t_ctl;

    logic en;

    // Stage A: products and simple ops
    logic                     r_a_vld;
    logic [CMD_W-1:0]         r_a_cmd;
    logic signed [DATA_W-1:0] r_a_re, r_a_im;
    logic                     r_a_clip;
    logic signed [PROD_W-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic signed [PROD_W-1:0] r_s_ar, r_s_ai, r_s_br, r_s_bi;
    logic signed [DATA_W-1:0] n_a_re, n_a_im;
    logic                     n_a_clip;

    // Stage B: sums
    logic                     r_b_vld;
    logic [CMD_W-1:0]         r_b_cmd;
    logic signed [DATA_W-1:0] r_b_re, r_b_im;
    logic                     r_b_clip;
    logic                     r_b_neg_r, r_b_neg_i;
    logic [PROD_W-1:0]        r_b_nr, r_b_ni, r_b_den, r_b_sq;
    logic signed [PROD_W:0]   n_mre, n_mim, n_nr, n_ni;
    logic [MAG_W-1:0]         n_mre_mag, n_mim_mag;
    t_sat                     n_sat_r, n_sat_i;

    // Stage C and divider / root stages
    logic              r_vld  [0:DIV_STG];
    t_ctl              r_ctl  [0:DIV_STG];
    logic [REM_W-1:0]  r_remr [0:DIV_STG];
    logic [REM_W-1:0]  r_remi [0:DIV_STG];
    logic [Q_W-1:0]    r_qr   [0:DIV_STG];
    logic [Q_W-1:0]    r_qi   [0:DIV_STG];
    logic [PROD_W-1:0] r_den  [0:DIV_STG];
    logic [ROOT_W-1:0] r_root [0:DIV_STG];
    logic [SREM_W-1:0] r_srem [0:DIV_STG];
    t_ctl              n_ctl  [1:DIV_STG];
    logic [REM_W-1:0]  n_remr [1:DIV_STG];
    logic [REM_W-1:0]  n_remi [1:DIV_STG];
    logic [Q_W-1:0]    n_qr   [1:DIV_STG];
    logic [Q_W-1:0]    n_qi   [1:DIV_STG];
    logic [ROOT_W-1:0] n_root [1:DIV_STG];
    logic [SREM_W-1:0] n_srem [1:DIV_STG];
    t_ctl              c_ctl;
    logic [REM_W-1:0]  c_numr, c_numi, c_dlim;

    // Output register
    logic                     r_o_vld;
    logic signed [DATA_W-1:0] r_o_re, r_o_im;
    logic [STAT_W-1:0]        r_o_st;
    logic signed [DATA_W-1:0] n_o_re, n_o_im;
    logic [STAT_W-1:0]        n_o_st;

    // Whole pipeline advances when the output slot is free or being drained
    assign en          = !r_o_vld || o_rsp.ready;
    assign i_req.ready = en;

    // Stage A: add, subtract, conjugate
    always_comb begin
        t_sat sr;
        t_sat si;
        sr = sat_s(18'sd0);
        si = sat_s(18'sd0);
        unique case (i_req.cmd)
            CMD_ADD: begin
                sr = sat_s((DATA_W+2)'(i_req.a_re) + (DATA_W+2)'(i_req.b_re));
                si = sat_s((DATA_W+2)'(i_req.a_im) + (DATA_W+2)'(i_req.b_im));
            end
            CMD_SUB: begin
                sr = sat_s((DATA_W+2)'(i_req.a_re) - (DATA_W+2)'(i_req.b_re));
                si = sat_s((DATA_W+2)'(i_req.a_im) - (DATA_W+2)'(i_req.b_im));
            end
            CMD_CONJ: begin
                sr = sat_s((DATA_W+2)'(i_req.a_re));
                si = sat_s(-(DATA_W+2)'(i_req.a_im));
            end
            default: begin
                sr = sat_s(18'sd0);
                si = sat_s(18'sd0);
            end
        endcase
        n_a_re   = sr.val;
        n_a_im   = si.val;
        n_a_clip = sr.clip | si.clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_cmd  <= i_req.cmd;
            r_a_re   <= n_a_re;
            r_a_im   <= n_a_im;
            r_a_clip <= n_a_clip;
            r_p_rr   <= PROD_W'(i_req.a_re * i_req.b_re);
            r_p_ii   <= PROD_W'(i_req.a_im * i_req.b_im);
            r_p_ri   <= PROD_W'(i_req.a_re * i_req.b_im);
            r_p_ir   <= PROD_W'(i_req.a_im * i_req.b_re);
            r_s_ar   <= PROD_W'(i_req.a_re * i_req.a_re);
            r_s_ai   <= PROD_W'(i_req.a_im * i_req.a_im);
            r_s_br   <= PROD_W'(i_req.b_re * i_req.b_re);
            r_s_bi   <= PROD_W'(i_req.b_im * i_req.b_im);
        end
    end

    // Stage B: product sums, multiply result, divider and root operands
    always_comb begin
        n_mre     = (PROD_W+1)'(r_p_rr) - (PROD_W+1)'(r_p_ii);
        n_mim     = (PROD_W+1)'(r_p_ri) + (PROD_W+1)'(r_p_ir);
        n_nr      = (PROD_W+1)'(r_p_rr) + (PROD_W+1)'(r_p_ii);
        n_ni      = (PROD_W+1)'(r_p_ir) - (PROD_W+1)'(r_p_ri);
        n_mre_mag = (n_mre[PROD_W] ? MAG_W'(-n_mre) : MAG_W'(n_mre)) >> FRAC_W;
        n_mim_mag = (n_mim[PROD_W] ? MAG_W'(-n_mim) : MAG_W'(n_mim)) >> FRAC_W;
        n_sat_r   = sat_sm(n_mre[PROD_W], n_mre_mag);
        n_sat_i   = sat_sm(n_mim[PROD_W], n_mim_mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_cmd <= r_a_cmd;
            if (r_a_cmd == CMD_MUL) begin
                r_b_re   <= n_sat_r.val;
                r_b_im   <= n_sat_i.val;
                r_b_clip <= n_sat_r.clip | n_sat_i.clip;
            end else begin
                r_b_re   <= r_a_re;
                r_b_im   <= r_a_im;
                r_b_clip <= r_a_clip;
            end
            r_b_neg_r <= n_nr[PROD_W];
            r_b_neg_i <= n_ni[PROD_W];
            r_b_nr    <= n_nr[PROD_W] ? PROD_W'(-n_nr) : PROD_W'(n_nr);
            r_b_ni    <= n_ni[PROD_W] ? PROD_W'(-n_ni) : PROD_W'(n_ni);
            r_b_den   <= PROD_W'(r_s_br) + PROD_W'(r_s_bi);
            r_b_sq    <= PROD_W'(r_s_ar) + PROD_W'(r_s_ai);
        end
    end

    // Stage C: scale dividends, flag division by zero and quotients too large for Q_W bits
    always_comb begin
        c_numr       = REM_W'({r_b_nr, {FRAC_W{1'b0}}});
        c_numi       = REM_W'({r_b_ni, {FRAC_W{1'b0}}});
        c_dlim       = {r_b_den, {Q_W{1'b0}}};
        c_ctl.cmd    = r_b_cmd;
        c_ctl.re     = r_b_re;
        c_ctl.im     = r_b_im;
        c_ctl.clip   = r_b_clip;
        c_ctl.dz     = (r_b_den == '0);
        c_ctl.neg_r  = r_b_neg_r;
        c_ctl.neg_i  = r_b_neg_i;
        c_ctl.ovf_r  = (c_numr >= c_dlim);
        c_ctl.ovf_i  = (c_numi >= c_dlim);
    end

    // Divider and root stages: one quotient bit each, one root bit in each of the first ROOT_W
    always_comb begin
        logic [REM_W-1:0]  dsh;
        logic [SREM_W-1:0] trial;
        for (int k = 1; k <= DIV_STG; k++) begin
            n_ctl[k]  = r_ctl[k-1];
            n_remr[k] = r_remr[k-1];
            n_remi[k] = r_remi[k-1];
            n_qr[k]   = r_qr[k-1];
            n_qi[k]   = r_qi[k-1];
            n_root[k] = r_root[k-1];
            n_srem[k] = r_srem[k-1];
            dsh = REM_W'(r_den[k-1]) << (DIV_STG - k);
            if (!r_ctl[k-1].ovf_r && (r_remr[k-1] >= dsh)) begin
                n_remr[k]              = r_remr[k-1] - dsh;
                n_qr[k][DIV_STG - k]   = 1'b1;
            end
            if (!r_ctl[k-1].ovf_i && (r_remi[k-1] >= dsh)) begin
                n_remi[k]              = r_remi[k-1] - dsh;
                n_qi[k][DIV_STG - k]   = 1'b1;
            end
            if (k <= ROOT_W) begin
                trial = (SREM_W'(r_root[k-1]) << (ROOT_W - k + 1))
                      | (SREM_W'(1) << (2 * (ROOT_W - k)));
                if (r_srem[k-1] >= trial) begin
                    n_srem[k]            = r_srem[k-1] - trial;
                    n_root[k][ROOT_W - k] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STG; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= r_b_vld;
            for (int k = 1; k <= DIV_STG; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctl[0]  <= c_ctl;
            r_remr[0] <= c_numr;
            r_remi[0] <= c_numi;
            r_qr[0]   <= '0;
            r_qi[0]   <= '0;
            r_den[0]  <= r_b_den;
            r_root[0] <= '0;
            r_srem[0] <= SREM_W'(r_b_sq);
            for (int k = 1; k <= DIV_STG; k++) begin
                r_ctl[k]  <= n_ctl[k];
                r_remr[k] <= n_remr[k];
                r_remi[k] <= n_remi[k];
                r_qr[k]   <= n_qr[k];
                r_qi[k]   <= n_qi[k];
                r_den[k]  <= r_den[k-1];
                r_root[k] <= n_root[k];
                r_srem[k] <= n_srem[k];
            end
        end
    end

    // Final selection and saturation
    always_comb begin
        t_ctl c;
        t_sat sr;
        t_sat si;
        c  = r_ctl[DIV_STG];
        sr = sat_sm(c.neg_r, c.ovf_r ? MAG_W'({Q_W{1'b1}}) : MAG_W'(r_qr[DIV_STG]));
        si = sat_sm(c.neg_i, c.ovf_i ? MAG_W'({Q_W{1'b1}}) : MAG_W'(r_qi[DIV_STG]));
        n_o_re = '0;
        n_o_im = '0;
        n_o_st = ST_OK;
        unique case (c.cmd)
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_CONJ: begin
                n_o_re = c.re;
                n_o_im = c.im;
                n_o_st = c.clip ? ST_SAT : ST_OK;
            end
            CMD_DIV: begin
                if (c.dz) begin
                    n_o_st = ST_DIV0;
                end else begin
                    n_o_re = sr.val;
                    n_o_im = si.val;
                    n_o_st = (sr.clip | si.clip) ? ST_SAT : ST_OK;
                end
            end
            CMD_MOD: begin
                sr     = sat_sm(1'b0, MAG_W'(r_root[DIV_STG]));
                n_o_re = sr.val;
                n_o_st = sr.clip ? ST_SAT : ST_OK;
            end
            default: begin
                n_o_st = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= r_vld[DIV_STG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_re <= n_o_re;
            r_o_im <= n_o_im;
            r_o_st <= n_o_st;
        end
    end

    assign o_rsp.valid  = r_o_vld;
    assign o_rsp.res_re = r_o_re;
    assign o_rsp.res_im = r_o_im;
    assign o_rsp.status = r_o_st;

    // Checks
    `CFPA_ASSERT_NXT(a_req_enters, i_req.valid && i_req.ready, r_a_vld,
        "accepted request did not reach the first stage")
    `CFPA_ASSERT_IMP(a_stall_blocks, o_rsp.valid && !o_rsp.ready, !i_req.ready,
        "request taken while response stalled")
    `CFPA_ASSERT_IMP(a_div0_zero, o_rsp.valid && (o_rsp.status == ST_DIV0),
        (o_rsp.res_re == '0) && (o_rsp.res_im == '0),
        "division by zero gave a non-zero result")

endmodule
`default_nettype wire

@@ bench/cfpa_checker.sv @@
// Checker: watches both channels, predicts each response and compares it.
module cfpa_checker import cfpa_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    cfpa_in_if.sink     i_req_mon,
    cfpa_out_if.sink    i_rsp_mon,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic [STAT_W-1:0]        st;
    } t_alu_result;

    t_alu_result result_queue[$];
    int          fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = result_queue.size();

    // Clamp a signed value to the data range, flagging any clamp
    function automatic logic signed [DATA_W-1:0] clamp16(input longint v, inout bit clip);
        if (v > 32767) begin
            clip = 1'b1;
            return 16'sh7fff;
        end
        if (v < -32768) begin
            clip = 1'b1;
            return 16'sh8000;
        end
        return v[DATA_W-1:0];
    endfunction

    // Truncate a signed value toward zero after an arithmetic right shift
    function automatic longint trunc_shift(input longint v);
        return (v < 0) ? -((-v) >>> FRAC_W) : (v >>> FRAC_W);
    endfunction

    // floor(n * 2^FRAC / den) on magnitudes, capped just above full scale
    function automatic longint div_mag(input longint n, input longint den);
        longint q;
        q = (n << FRAC_W) / den;
        return (q > 32769) ? 32769 : q;
    endfunction

    // Root of a sum of two squares; the answer stays below 2^17
    function automatic longint int_sqrt(input longint s);
        longint r;
        r = 0;
        for (longint b = 64'sd1 << 20; b > 0; b = b >> 1)
            if ((r + b) * (r + b) <= s) r = r + b;
        return r;
    endfunction

    function automatic t_alu_result predict_alu(input logic [CMD_W-1:0] cmd,
                                                input longint ar, input longint ai,
                                                input longint br, input longint bi);
        t_alu_result r;
        bit     clip;
        longint nr, ni, den;
        clip = 1'b0;
        r    = '0;
        case (cmd)
            CMD_ADD: begin
                r.re = clamp16(ar + br, clip);
                r.im = clamp16(ai + bi, clip);
            end
            CMD_SUB: begin
                r.re = clamp16(ar - br, clip);
                r.im = clamp16(ai - bi, clip);
            end
            CMD_MUL: begin
                r.re = clamp16(trunc_shift(ar * br - ai * bi), clip);
                r.im = clamp16(trunc_shift(ar * bi + ai * br), clip);
            end
            CMD_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.st = ST_DIV0;
                end else begin
                    nr = ar * br + ai * bi;
                    ni = ai * br - ar * bi;
                    nr = (nr < 0) ? -div_mag(-nr, den) : div_mag(nr, den);
                    ni = (ni < 0) ? -div_mag(-ni, den) : div_mag(ni, den);
                    r.re = clamp16(nr, clip);
                    r.im = clamp16(ni, clip);
                end
            end
            CMD_MOD:  r.re = clamp16(int_sqrt(ar * ar + ai * ai), clip);
            CMD_CONJ: begin
                r.re = ar[DATA_W-1:0];
                r.im = clamp16(-ai, clip);
            end
            default: ;
        endcase
        if (r.st == ST_OK && clip) r.st = ST_SAT;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("ERROR: %s got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    // Predict on each accepted request, compare on each accepted response
    always @(posedge i_clk) begin
        t_alu_result want;
        if (!i_rst_n) begin
            fail_count <= 0;
        end else begin
            if (i_req_mon.valid && i_req_mon.ready)
                result_queue.push_back(predict_alu(i_req_mon.cmd, i_req_mon.a_re,
                    i_req_mon.a_im, i_req_mon.b_re, i_req_mon.b_im));
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                if (result_queue.size() == 0) begin
                    report_mismatch("unexpected response, re", i_rsp_mon.res_re, 0);
                end else begin
                    want = result_queue.pop_front();
                    if (i_rsp_mon.res_re !== want.re)
                        report_mismatch("res_re", i_rsp_mon.res_re, want.re);
                    if (i_rsp_mon.res_im !== want.im)
                        report_mismatch("res_im", i_rsp_mon.res_im, want.im);
                    if (i_rsp_mon.status !== want.st)
                        report_mismatch("status", i_rsp_mon.status, want.st);
                end
            end
        end
    end
endmodule

@@ bench/testbench.sv @@
// Testbench top: clock, reset, request stimulus, response back-pressure, verdict.
module testbench import cfpa_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 21;
    localparam int N_RANDOM  = 1200;
    localparam int MAX_CYCLE = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count, pending, cycle_count;
    bit   sink_hold, no_idle;

    cfpa_in_if  req_if ();
    cfpa_out_if rsp_if ();

    complex_fixed_point_alu_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_if.sink), .o_rsp(rsp_if.source));

    cfpa_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req_mon(req_if.sink),
        .i_rsp_mon(rsp_if.sink), .o_fail_count(fail_count), .o_pending(pending));

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Response back-pressure: random idling, plus a held-off stretch
    always @(posedge i_clk)
        rsp_if.ready <= !sink_hold && (no_idle || $urandom_range(99) >= 22);

    initial begin
        sink_hold = 1'b0;
        repeat (300) @(posedge i_clk);
        sink_hold = 1'b1;
        repeat (80) @(posedge i_clk);
        sink_hold = 1'b0;
    end

    function automatic logic signed [DATA_W-1:0] pick_operand();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return $signed(16'($urandom_range(1023))) - 16'sd512;
            default: return $signed(16'($urandom()));
        endcase
    endfunction

    // Offer one request and hold it until taken
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] ar,
                                input logic [DATA_W-1:0] ai, input logic [DATA_W-1:0] br,
                                input logic [DATA_W-1:0] bi);
        while (!no_idle && $urandom_range(99) < 22) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.cmd   <= cmd;
        req_if.a_re  <= ar;
        req_if.a_im  <= ai;
        req_if.b_re  <= br;
        req_if.b_im  <= bi;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    initial begin
        cycle_count  = 0;
        no_idle      = 1'b0;
        req_if.valid = 1'b0;
        req_if.cmd   = '0;
        req_if.a_re  = '0;
        req_if.a_im  = '0;
        req_if.b_re  = '0;
        req_if.b_im  = '0;
        rsp_if.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every operation, division by zero, unused codes
        for (int c = 0; c < 8; c++) begin
            send_request(CMD_W'(c), 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
            send_request(CMD_W'(c), 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        end
        send_request(CMD_DIV, 16'sh0100, 16'sh0200, 16'sh0000, 16'sh0000);
        send_request(CMD_DIV, 16'sh7fff, 16'sh7fff, 16'sh0001, 16'sh0000);
        send_request(CMD_CONJ, 16'sh1234, 16'sh8000, 16'sh0000, 16'sh0000);
        send_request(CMD_MOD, 16'sh7fff, 16'sh7fff, 16'shffff, 16'shffff);
        send_request(CMD_MUL, 16'sh0100, 16'sh0100, 16'sh0100, 16'shff00);

        // Pause until everything has drained
        req_if.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);

        // Random part, with a no-idle stretch in the middle
        for (int n = 0; n < N_RANDOM; n++) begin
            no_idle = (n >= 500 && n < 700);
            send_request(($urandom_range(15) == 0) ? 3'($urandom_range(7, 6))
                                                   : 3'($urandom_range(5)),
                         pick_operand(), pick_operand(),
                         ($urandom_range(9) == 0) ? 16'sh0 : pick_operand(),
                         ($urandom_range(9) == 0) ? 16'sh0 : pick_operand());
        end
        no_idle = 1'b0;
        req_if.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
